// ===== sv/wuia_pkg.sv =====
`default_nettype none

package wuia_pkg;

    // field widths of the channel payloads
    localparam int DATA_W     = 64;
    localparam int OP_W       = 3;
    localparam int DIGITS_DEF = 16;

    // operation codes
    localparam logic [OP_W-1:0] OP_ADD = 3'd0;
    localparam logic [OP_W-1:0] OP_SUB = 3'd1;
    localparam logic [OP_W-1:0] OP_MUL = 3'd2;
    localparam logic [OP_W-1:0] OP_DIV = 3'd3;
    localparam logic [OP_W-1:0] OP_POW = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [DATA_W-1:0] operand_a;
        logic [DATA_W-1:0] operand_b;
    } t_in;

    typedef struct packed {
        logic [DATA_W-1:0] result;
        logic [DATA_W-1:0] remainder;
        logic              negative;
        logic              divide_by_zero;
    } t_out;

endpackage

`default_nettype wire

// ===== sv/wuia_mul.sv =====
`default_nettype none

// truncated multiplier, one hex digit of the multiplier per cycle
module wuia_mul #(
    parameter int W = 64
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire logic [W-1:0] i_a,
    input  wire logic [W-1:0] i_b,
    output logic              o_done,
    output logic [W-1:0]      o_p
);

    localparam int NDIG = W / 4;
    localparam int CW   = $clog2(NDIG + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_a;
    logic [W-1:0]  r_b;
    logic [W-1:0]  r_acc;
    logic [W+3:0]  w_pp;

    // partial product of the shifted multiplicand and the current digit
    assign w_pp = {4'b0, r_a} * {{W{1'b0}}, r_b[3:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CW'(NDIG - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_acc <= r_acc + w_pp[W-1:0];
            r_a   <= r_a << 4;
            r_b   <= r_b >> 4;
            r_cnt <= r_cnt + CW'(1);
        end
    end

    assign o_done = r_done;
    assign o_p    = r_acc;

endmodule

`default_nettype wire

// ===== sv/wuia_div.sv =====
`default_nettype none

// restoring divider, one quotient bit per cycle
module wuia_div #(
    parameter int W = 64
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire logic [W-1:0] i_a,
    input  wire logic [W-1:0] i_b,
    output logic              o_done,
    output logic [W-1:0]      o_q,
    output logic [W-1:0]      o_r
);

    localparam int CW = $clog2(W + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_q;
    logic [W-1:0]  r_r;
    logic [W-1:0]  r_d;
    logic [W:0]    w_trial;
    logic [W:0]    w_diff;
    logic          w_ge;

    assign w_trial = {r_r, r_q[W-1]};
    assign w_diff  = w_trial - {1'b0, r_d};
    assign w_ge    = w_trial >= {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CW'(W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_a;
            r_r   <= '0;
            r_d   <= i_b;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_r   <= w_ge ? w_diff[W-1:0] : w_trial[W-1:0];
            r_q   <= {r_q[W-2:0], w_ge};
            r_cnt <= r_cnt + CW'(1);
        end
    end

    assign o_done = r_done;
    assign o_q    = r_q;
    assign o_r    = r_r;

endmodule

`default_nettype wire

// ===== sv/wide_unsigned_integer_alu_core.sv =====
// channel  | valid       | ready       | payload
// ---------+-------------+-------------+---------------------------------
// input    | i_in_valid  | o_in_ready  | i_in  : op, operand_a, operand_b
// output   | o_out_valid | i_out_ready | o_out : result, remainder, flags
//
// one item at a time; add, subtract, zero-divisor divide and unused codes go straight
// to S_DONE, multiply waits in S_MUL and divide in S_DIV for its unit's done
// power: one multiply per set exponent bit plus one squaring per bit below the top
// set bit, each through the shared digit-serial multiplier.
// ready again once the result is loaded; a result stalled in the output register
// holds the next one in S_DONE. sync active-low reset clears sequencer and out valid
`default_nettype none

module wide_unsigned_integer_alu_core #(
    parameter int DIGITS = wuia_pkg::DIGITS_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire wuia_pkg::t_in  i_in,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output wuia_pkg::t_out      o_out
);

    localparam int W = 4 * DIGITS;

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_PCHK = 3'd3;
    localparam logic [2:0] S_PACC = 3'd4;
    localparam logic [2:0] S_PSQ  = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0]     r_state, n_state;
    logic [W-1:0]   r_res, n_res;
    logic [W-1:0]   r_rem, n_rem;
    logic           r_neg, n_neg;
    logic           r_dbz, n_dbz;
    // power: accumulator, running square, remaining exponent
    logic [W-1:0]   r_acc, n_acc;
    logic [W-1:0]   r_base, n_base;
    logic [W-1:0]   r_exp, n_exp;
    logic           r_out_valid;
    wuia_pkg::t_out r_out;

    logic [W-1:0]   w_a;
    logic [W-1:0]   w_b;
    logic [W:0]     w_sub;
    logic           w_out_free;

    logic           w_mul_start;
    logic [W-1:0]   w_mul_a;
    logic [W-1:0]   w_mul_b;
    logic           w_mul_done;
    logic [W-1:0]   w_mul_p;
    logic           w_div_start;
    logic           w_div_done;
    logic [W-1:0]   w_div_q;
    logic [W-1:0]   w_div_r;

    // only the low DIGITS hex digits of each operand count
    assign w_a   = i_in.operand_a[W-1:0];
    assign w_b   = i_in.operand_b[W-1:0];
    // top bit is the borrow out
    assign w_sub = {1'b0, w_a} - {1'b0, w_b};

    assign w_out_free = !r_out_valid || i_out_ready;

    wuia_mul #(
        .W (W)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_done  (w_mul_done),
        .o_p     (w_mul_p)
    );

    wuia_div #(
        .W (W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_a     (w_a),
        .i_b     (w_b),
        .o_done  (w_div_done),
        .o_q     (w_div_q),
        .o_r     (w_div_r)
    );

    always_comb begin
        n_state     = r_state;
        n_res       = r_res;
        n_rem       = r_rem;
        n_neg       = r_neg;
        n_dbz       = r_dbz;
        n_acc       = r_acc;
        n_base      = r_base;
        n_exp       = r_exp;
        w_mul_start = 1'b0;
        w_mul_a     = r_base;
        w_mul_b     = r_base;
        w_div_start = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_res   = '0;
                    n_rem   = '0;
                    n_neg   = 1'b0;
                    n_dbz   = 1'b0;
                    n_state = S_DONE;
                    case (i_in.op)
                        wuia_pkg::OP_ADD: begin
                            n_res = w_a + w_b;
                        end
                        wuia_pkg::OP_SUB: begin
                            n_res = w_sub[W-1:0];
                            n_neg = w_sub[W];
                        end
                        wuia_pkg::OP_MUL: begin
                            w_mul_start = 1'b1;
                            w_mul_a     = w_a;
                            w_mul_b     = w_b;
                            n_state     = S_MUL;
                        end
                        wuia_pkg::OP_DIV: begin
                            if (w_b == '0) begin
                                n_dbz = 1'b1;
                            end else begin
                                w_div_start = 1'b1;
                                n_state     = S_DIV;
                            end
                        end
                        wuia_pkg::OP_POW: begin
                            n_acc   = W'(1);
                            n_base  = w_a;
                            n_exp   = w_b;
                            n_state = S_PCHK;
                        end
                        default: begin
                            // unused codes give an all-zero item
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_MUL: begin
                if (w_mul_done) begin
                    n_res   = w_mul_p;
                    n_state = S_DONE;
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_res   = w_div_q;
                    n_rem   = w_div_r;
                    n_state = S_DONE;
                end
            end
            S_PCHK: begin
                // low exponent bit set: fold base into acc first, then square
                if (r_exp == '0) begin
                    n_res   = r_acc;
                    n_state = S_DONE;
                end else if (r_exp[0]) begin
                    w_mul_start = 1'b1;
                    w_mul_a     = r_acc;
                    w_mul_b     = r_base;
                    n_state     = S_PACC;
                end else begin
                    w_mul_start = 1'b1;
                    n_state     = S_PSQ;
                end
            end
            S_PACC: begin
                if (w_mul_done) begin
                    n_acc   = w_mul_p;
                    n_exp   = {r_exp[W-1:1], 1'b0};
                    n_state = S_PCHK;
                end
            end
            S_PSQ: begin
                if (w_mul_done) begin
                    n_base  = w_mul_p;
                    n_exp   = r_exp >> 1;
                    n_state = S_PCHK;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res  <= n_res;
        r_rem  <= n_rem;
        r_neg  <= n_neg;
        r_dbz  <= n_dbz;
        r_acc  <= n_acc;
        r_base <= n_base;
        r_exp  <= n_exp;
        if (r_state == S_DONE && w_out_free) begin
            r_out.result         <= wuia_pkg::DATA_W'(r_res);
            r_out.remainder      <= wuia_pkg::DATA_W'(r_rem);
            r_out.negative       <= r_neg;
            r_out.divide_by_zero <= r_dbz;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire

// ===== sv/wuia_chk.sv =====
`default_nettype none

module wuia_chk (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           i_in_valid,
    input wire logic           i_in_ready,
    input wire wuia_pkg::t_in  i_in,
    input wire logic           i_out_valid,
    input wire logic           i_out_ready,
    input wire wuia_pkg::t_out i_out
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result item dropped while stalled");

    // one item at a time: no accept right after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input taken while previous item in progress");

    // a zero divisor gives zero quotient and remainder
    a_dbz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out.divide_by_zero |->
            i_out.result == '0 && i_out.remainder == '0)
        else $error("divide by zero with nonzero result");

    // flags belong to different operations
    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_out.negative && i_out.divide_by_zero))
        else $error("borrow and divide-by-zero both set");

    // a waiting input item stays offered and unchanged
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !i_in_ready |=> i_in_valid && $stable(i_in))
        else $error("input item changed while waiting");

endmodule

bind wide_unsigned_integer_alu_core wuia_chk u_wuia_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_ready  (o_in_ready),
    .i_in        (i_in),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_out       (o_out)
);

`default_nettype wire
